// ----- rtl/core/clock_offset_window_max_estimator_top_defines.svh -----
// Assertion macros shared by the clock offset estimator RTL.
`ifndef CLOCK_OFFSET_WINDOW_MAX_ESTIMATOR_TOP_DEFINES_SVH
`define CLOCK_OFFSET_WINDOW_MAX_ESTIMATOR_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause; expects clk and rst in scope.
`define CLKOFF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause; expects clk and rst in scope.
`define CLKOFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/clkoff_pkg.sv -----
// Shared widths, register codes and beat types of the clock offset estimator.
package clkoff_pkg;

  // Field widths
  localparam int NOW_W    = 63;
  localparam int TICK_W   = 40;
  localparam int RATE_W   = 48;
  localparam int WINDOW_W = 40;
  localparam int DELAY_W  = 32;
  localparam int Q16_W    = 57;
  localparam int LOCAL_W  = 56;
  localparam int FRAC_Q   = 16;
  localparam int PROD_W   = NOW_W + RATE_W;

  // Register port
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 5;
  localparam int REG_IDX_LSB = 3;
  localparam int REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_TICK_RATE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_NS   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DELAY_TICKS = 2'd2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 40'd2000000000;

  localparam logic signed [Q16_W-1:0] Q16_MAX = {1'b0, {(Q16_W-1){1'b1}}};
  localparam logic signed [Q16_W-1:0] Q16_MIN = {1'b1, {(Q16_W-1){1'b0}}};

  typedef struct packed {
    logic [NOW_W-1:0]  now_ns;
    logic              has_server_tick;
    logic [TICK_W-1:0] server_tick;
    logic              clear_history;
  } item_t;

  typedef struct packed {
    logic signed [Q16_W-1:0] perceived_tick;
    logic                    estimate_valid;
  } result_t;

  typedef struct packed {
    logic [NOW_W-1:0]        stamp;
    logic signed [Q16_W-1:0] offset;
  } entry_t;

  typedef struct packed {
    logic [RATE_W-1:0]   tick_rate;
    logic [WINDOW_W-1:0] window_ns;
    logic [DELAY_W-1:0]  delay_ticks;
  } cfg_regs_t;

endpackage

// ----- rtl/core/clkoff_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module clkoff_ram #(
  parameter int WIDTH = 120,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/clkoff_mul.sv -----
// Serial 63x48 multiplier giving local ticks as saturated unsigned Q.16.
module clkoff_mul import clkoff_pkg::*; #(
  parameter int RATE_FRAC_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NOW_W-1:0]   now_ns,
  input  logic [RATE_W-1:0]  tick_rate,
  output logic               done,
  output logic [LOCAL_W-1:0] local_ticks
);

  localparam int HALF_W   = 32;
  localparam int SHIFT    = RATE_FRAC_BITS - FRAC_Q;
  localparam int TOP_LSB  = SHIFT + LOCAL_W;
  localparam int PP_COUNT = 4;
  localparam int STEP_W   = 3;

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic                prod_vld;
  logic [1:0]          prod_idx;
  logic [NOW_W-1:0]    a_q;
  logic [RATE_W-1:0]   b_q;
  logic [HALF_W-1:0]   op_a;
  logic [HALF_W-1:0]   op_b;
  logic [2*HALF_W-1:0] prod;
  logic [PROD_W-1:0]   addend;
  logic [PROD_W-1:0]   acc;
  logic                over;

  // Pick the halves for this partial product: bit 1 selects now_ns, bit 0 the rate
  assign op_a = step[1] ? HALF_W'(a_q[NOW_W-1:HALF_W]) : a_q[HALF_W-1:0];
  assign op_b = step[0] ? HALF_W'(b_q[RATE_W-1:HALF_W]) : b_q[HALF_W-1:0];

  // Align the registered partial product to its weight
  always_comb begin
    case (prod_idx)
      2'd0:    addend = PROD_W'(prod);
      2'd1:    addend = PROD_W'(prod) << HALF_W;
      2'd2:    addend = PROD_W'(prod) << HALF_W;
      default: addend = PROD_W'(prod) << (2 * HALF_W);
    endcase
  end

  // Multiply one partial product a cycle, accumulate it the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      prod_vld <= 1'b0;
      step     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        prod_vld <= 1'b0;
        a_q      <= now_ns;
        b_q      <= tick_rate;
        acc      <= '0;
      end else if (busy) begin
        if (prod_vld) begin
          acc <= acc + addend;
        end
        if (step != STEP_W'(PP_COUNT)) begin
          prod     <= op_a * op_b;
          prod_idx <= step[1:0];
          prod_vld <= 1'b1;
          step     <= step + STEP_W'(1);
        end else begin
          prod_vld <= 1'b0;
          busy     <= 1'b0;
          done     <= 1'b1;
        end
      end
    end
  end

  // Truncate to Q.16 and saturate to the largest local tick count
  assign over        = |acc[PROD_W-1:TOP_LSB];
  assign local_ticks = over ? '1 : acc[TOP_LSB-1:SHIFT];

endmodule

// ----- rtl/core/clkoff_regs.sv -----
// APB-style register file holding tick rate, window and delay.
module clkoff_regs import clkoff_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_regs_t             cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_IDX_LSB +: REG_IDX_W];
  assign wr_en   = psel & penable & pwrite & pready;

  // Write on the access phase; drop writes outside the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_rate   <= '0;
      cfg.window_ns   <= WINDOW_RESET;
      cfg.delay_ticks <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TICK_RATE:   cfg.tick_rate   <= pwdata[RATE_W-1:0];
        REG_WINDOW_NS:   cfg.window_ns   <= pwdata[WINDOW_W-1:0];
        REG_DELAY_TICKS: cfg.delay_ticks <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_TICK_RATE:   prdata = APB_DATA_W'(cfg.tick_rate);
      REG_WINDOW_NS:   prdata = APB_DATA_W'(cfg.window_ns);
      REG_DELAY_TICKS: prdata = APB_DATA_W'(cfg.delay_ticks);
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/clock_offset_window_max_estimator_top.sv -----
// Top level of the clock offset estimator: history deque in RAM and item sequencer.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+--------------------------------
//   item     | item_valid / item_stall      | item_t: now_ns, tick, clear
//   result   | result_valid / result_stall  | result_t: perceived_tick, valid
//   config   | psel/penable/pwrite, pready  | paddr, pwdata, prdata (64 bit)
//
// One item at a time: without a server tick the result is loaded after the multiply, a
// front read and the estimate; with one, dominated entries are first popped from the back,
// the offset appended and expired entries dropped from the front. The next item is taken in
// the cycle after. The serial multiplier and the registered RAM read per step set the pace.
// Reset is synchronous; the history is empty afterwards, no clearing pass.
// A result waiting under result_stall does not block the next item, only its result.
`include "clock_offset_window_max_estimator_top_defines.svh"

module clock_offset_window_max_estimator_top import clkoff_pkg::*; #(
  parameter int HISTORY_DEPTH  = 32,
  parameter int RATE_FRAC_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;
  localparam int EST_W = Q16_W + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_BACK_RD,
    S_BACK_CMP,
    S_APPEND,
    S_EXP_RD,
    S_EXP_CMP,
    S_FRONT_RD,
    S_CALC,
    S_DONE
  } state_t;

  state_t                  state;
  cfg_regs_t               cfg;
  item_t                   itm;
  logic [PTR_W-1:0]        head;
  logic [CNT_W-1:0]        count;
  logic [LOCAL_W-1:0]      local_ticks;
  logic signed [Q16_W-1:0] off;
  result_t                 res;

  logic                    take;
  logic                    mul_done;
  logic [LOCAL_W-1:0]      mul_q16;
  logic signed [Q16_W-1:0] new_off;
  logic                    ram_we;
  logic [PTR_W-1:0]        ram_waddr;
  logic [PTR_W-1:0]        ram_raddr;
  entry_t                  ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                  rd_entry;
  logic [SUM_W-1:0]        back_sum;
  logic [SUM_W-1:0]        app_sum;
  logic [PTR_W-1:0]        back_addr;
  logic [PTR_W-1:0]        app_addr;
  logic [PTR_W-1:0]        head_inc;
  logic                    full;
  logic                    expired;
  logic signed [EST_W-1:0] est_sum;
  logic signed [Q16_W-1:0] est_sat;
  logic                    est_valid;

  clkoff_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clkoff_mul #(
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_mul (
    .clk         (clk),
    .rst         (rst),
    .start       (take),
    .now_ns      (item.now_ns),
    .tick_rate   (cfg.tick_rate),
    .done        (mul_done),
    .local_ticks (mul_q16)
  );

  clkoff_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign item_stall = (state != S_IDLE);
  assign take       = item_valid && !item_stall;
  assign rd_entry   = entry_t'(ram_rdata);

  // Ring addresses of the back entry, the append slot and the next front
  assign back_sum  = {1'b0, head} + SUM_W'(count - CNT_W'(1));
  assign app_sum   = {1'b0, head} + SUM_W'(count);
  assign back_addr = (back_sum >= SUM_W'(HISTORY_DEPTH)) ?
                     PTR_W'(back_sum - SUM_W'(HISTORY_DEPTH)) : PTR_W'(back_sum);
  assign app_addr  = (app_sum >= SUM_W'(HISTORY_DEPTH)) ?
                     PTR_W'(app_sum - SUM_W'(HISTORY_DEPTH)) : PTR_W'(app_sum);
  assign head_inc  = (head == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign full      = (count == CNT_W'(HISTORY_DEPTH));

  // Read the back while popping, otherwise keep the front on the read port
  assign ram_raddr = (state == S_BACK_RD) ? back_addr : head;

  // Append the new offset; when full it overwrites the oldest slot
  assign ram_we           = (state == S_APPEND);
  assign ram_waddr        = full ? head : app_addr;
  assign ram_wdata.stamp  = itm.now_ns;
  assign ram_wdata.offset = off;

  // Offset of a received tick against local ticks
  assign new_off = $signed({1'b0, itm.server_tick, {FRAC_Q{1'b0}}}) - $signed({1'b0, mul_q16});

  // Front entry older than the window
  assign expired = ({1'b0, rd_entry.stamp} + (NOW_W + 1)'(cfg.window_ns)) < {1'b0, itm.now_ns};

  // Estimate from local ticks, front offset and delay, saturated to Q.16
  assign est_sum = $signed({2'b00, 1'b0, local_ticks})
                 + $signed({{2{rd_entry.offset[Q16_W-1]}}, rd_entry.offset})
                 - $signed({(EST_W - DELAY_W - FRAC_Q)'(0), cfg.delay_ticks, {FRAC_Q{1'b0}}});
  assign est_valid = (count != '0) && (cfg.tick_rate != '0);

  always_comb begin
    if (est_sum[EST_W-1:Q16_W-1] != 3'b000 && est_sum[EST_W-1:Q16_W-1] != 3'b111) begin
      est_sat = est_sum[EST_W-1] ? Q16_MIN : Q16_MAX;
    end else begin
      est_sat = est_sum[Q16_W-1:0];
    end
  end

  // Sequencer: multiply, then with a server tick pop back, append and expire front, then estimate
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      // Drop an accepted result beat unless a new one replaces it this cycle
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            itm <= item;
            if (item.clear_history) begin
              count <= '0;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            local_ticks <= mul_q16;
            off         <= new_off;
            state       <= itm.has_server_tick ? S_BACK_RD : S_FRONT_RD;
          end
        end
        S_BACK_RD: begin
          state <= (count == '0) ? S_APPEND : S_BACK_CMP;
        end
        S_BACK_CMP: begin
          if (rd_entry.offset <= off) begin
            count <= count - CNT_W'(1);
            state <= S_BACK_RD;
          end else begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          if (full) begin
            head <= head_inc;
          end else begin
            count <= count + CNT_W'(1);
          end
          state <= S_EXP_RD;
        end
        S_EXP_RD: begin
          state <= (count == '0) ? S_FRONT_RD : S_EXP_CMP;
        end
        S_EXP_CMP: begin
          if (expired) begin
            head  <= head_inc;
            count <= count - CNT_W'(1);
            state <= S_EXP_RD;
          end else begin
            state <= S_CALC;
          end
        end
        S_FRONT_RD: begin
          state <= S_CALC;
        end
        S_CALC: begin
          res.perceived_tick <= est_valid ? est_sat : '0;
          res.estimate_valid <= est_valid;
          state              <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `CLKOFF_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(HISTORY_DEPTH), "history overfull")
  `CLKOFF_ASSERT_SAME(a_pop_nonempty, state == S_BACK_CMP, count != '0, "pop from empty history")
  `CLKOFF_ASSERT_NEXT(a_take_busy, take, state == S_MUL, "accepted beat not being worked on")
  `CLKOFF_ASSERT_SAME(a_invalid_zero, result_valid && !result.estimate_valid,
                      result.perceived_tick == '0, "invalid estimate carries a value")

endmodule

// ----- sim/clock_offset_window_max_estimator_top_test.sv -----
// Self-checking testbench for the clock offset estimator: directed and random beats, own predictor.
module clock_offset_window_max_estimator_top_test;
  import clkoff_pkg::*;

  localparam int HISTORY_DEPTH  = 32;
  localparam int RATE_FRAC_BITS = 48;
  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 100;
  localparam int IDLE_PERCENT   = 18;

  localparam longint EST_HI = 64'sh00FF_FFFF_FFFF_FFFF;
  localparam longint EST_LO = -EST_HI - 1;

  localparam logic [NOW_W-1:0]    NOW_MAX    = '1;
  localparam logic [TICK_W-1:0]   TICK_MAX   = '1;
  localparam logic [RATE_W-1:0]   RATE_MAX   = '1;
  localparam logic [WINDOW_W-1:0] WINDOW_MAX = '1;
  localparam logic [DELAY_W-1:0]  DELAY_MAX  = '1;
  // roughly 60 server ticks per second
  localparam logic [RATE_W-1:0]   RATE_60HZ  = 48'd16888498;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  item_t                 item_beat    = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result_beat;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0] paddr        = '0;
  logic [APB_DATA_W-1:0] pwdata       = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor copy of the registers and the history deque
  logic [RATE_W-1:0]   model_rate   = '0;
  logic [WINDOW_W-1:0] model_window = WINDOW_RESET;
  logic [DELAY_W-1:0]  model_delay  = '0;
  entry_t              offset_history[$];
  result_t             expected_estimates[$];
  result_t             oldest_estimate;

  int fail_count = 0;
  bit no_idle    = 1'b0;

  logic [NOW_W-1:0] clock_now = '0;

  clock_offset_window_max_estimator_top #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .RATE_FRAC_BITS(RATE_FRAC_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item_beat),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #(2 * CLK_HALF * 1000000);
    $display("== FAIL ==");
    $finish;
  end

  // Stall the result side at random, except in the steady stretch
  always @(posedge clk) begin
    result_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch in %s: expected %h, got %h", what, want, got);
  endtask

  // Local ticks as Q.16: floor of now * rate, saturated to 56 bits
  function automatic logic [LOCAL_W-1:0] local_ticks(input logic [NOW_W-1:0] now);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] scaled;
    prod   = PROD_W'(now) * PROD_W'(model_rate);
    scaled = prod >> (RATE_FRAC_BITS - FRAC_Q);
    if ((scaled >> LOCAL_W) != 0)
      return '1;
    return scaled[LOCAL_W-1:0];
  endfunction

  // Advance the predicted deque by one item and work out its estimate
  function automatic result_t predict_estimate(input item_t it);
    logic [LOCAL_W-1:0] loc;
    longint             off;
    longint             est;
    entry_t             fresh;
    result_t            r;
    loc = local_ticks(it.now_ns);
    r   = '0;
    if (it.clear_history)
      offset_history.delete();
    if (it.has_server_tick) begin
      off = {8'd0, it.server_tick, 16'd0};
      off = off - longint'({8'd0, loc});
      // drop back entries that the new offset dominates
      while (offset_history.size() > 0 && offset_history[$].offset <= off)
        offset_history.delete(offset_history.size() - 1);
      if (offset_history.size() >= HISTORY_DEPTH)
        offset_history.delete(0);
      fresh.stamp  = it.now_ns;
      fresh.offset = off[Q16_W-1:0];
      offset_history = {offset_history, fresh};
      // expire from the front only
      while (offset_history.size() > 0 &&
             {1'b0, offset_history[0].stamp} + {24'd0, model_window} < {1'b0, it.now_ns})
        offset_history.delete(0);
    end
    r.estimate_valid = offset_history.size() > 0 && model_rate != 0;
    if (r.estimate_valid) begin
      est = longint'({8'd0, loc}) + longint'(offset_history[0].offset)
            - longint'({16'd0, model_delay, 16'd0});
      if (est > EST_HI)
        est = EST_HI;
      if (est < EST_LO)
        est = EST_LO;
      r.perceived_tick = est[Q16_W-1:0];
    end
    return r;
  endfunction

  // Compare each accepted result beat with the oldest estimate
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_estimates.size() == 0) begin
        report_mismatch("unexpected result beat", '0, 64'(result_beat));
      end else begin
        oldest_estimate = expected_estimates[0];
        expected_estimates.delete(0);
        if (result_beat.perceived_tick !== oldest_estimate.perceived_tick)
          report_mismatch("perceived_tick", 64'(oldest_estimate.perceived_tick),
                          64'(result_beat.perceived_tick));
        if (result_beat.estimate_valid !== oldest_estimate.estimate_valid)
          report_mismatch("estimate_valid", 64'(oldest_estimate.estimate_valid),
                          64'(result_beat.estimate_valid));
      end
    end
  end

  function automatic logic [NOW_W-1:0] rand_now();
    return NOW_W'({$urandom, $urandom});
  endfunction

  function automatic item_t make_item(input logic [NOW_W-1:0] now, input logic has,
                                      input logic [TICK_W-1:0] tick, input logic clr);
    item_t it;
    it.now_ns          = now;
    it.has_server_tick = has;
    it.server_tick     = tick;
    it.clear_history   = clr;
    return it;
  endfunction

  // Server tick near the local estimate, lead ticks ahead, clamped to the field
  function automatic logic [TICK_W-1:0] tick_near(input logic [NOW_W-1:0] now,
                                                  input longint lead);
    longint v;
    v = longint'({24'd0, local_ticks(now) >> FRAC_Q}) + lead;
    if (v < 0)
      v = 0;
    if (v > longint'({24'd0, TICK_MAX}))
      v = {24'd0, TICK_MAX};
    return v[TICK_W-1:0];
  endfunction

  // Send one item beat, idling at random first, and queue its estimate
  task automatic send_item(input item_t it);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_beat  <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall)
      @(posedge clk);
    expected_estimates = {expected_estimates, predict_estimate(it)};
  endtask

  // Wait until every estimate has arrived and the block has settled
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_estimates.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [63:0] wdata, output logic [63:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'(idx) << REG_IDX_LSB;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [REG_IDX_W-1:0] idx, input logic [63:0] want);
    logic [63:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== want)
      report_mismatch("register read", want, got);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    logic [63:0] scratch;
    logic [63:0] kept;
    case (idx)
      REG_TICK_RATE: begin
        model_rate = value[RATE_W-1:0];
        kept       = {16'd0, model_rate};
      end
      REG_WINDOW_NS: begin
        model_window = value[WINDOW_W-1:0];
        kept         = {24'd0, model_window};
      end
      default: begin
        model_delay = value[DELAY_W-1:0];
        kept        = {32'd0, model_delay};
      end
    endcase
    apb_access(1'b1, idx, value, scratch);
    check_register(idx, kept);
  endtask

  task automatic set_config(input logic [RATE_W-1:0] rate, input logic [WINDOW_W-1:0] win,
                            input logic [DELAY_W-1:0] dly);
    drain();
    write_register(REG_TICK_RATE, {16'd0, rate});
    write_register(REG_WINDOW_NS, {24'd0, win});
    write_register(REG_DELAY_TICKS, {32'd0, dly});
  endtask

  task automatic test_register_defaults();
    check_register(REG_TICK_RATE, '0);
    check_register(REG_WINDOW_NS, {24'd0, WINDOW_RESET});
    check_register(REG_DELAY_TICKS, '0);
  endtask

  // Rate zero: estimates stay invalid but server ticks are still kept
  task automatic test_rate_zero();
    send_item(make_item(63'd1000, 1'b0, '0, 1'b0));
    send_item(make_item(63'd2000, 1'b1, 40'd500, 1'b0));
    send_item(make_item(63'd3000, 1'b0, '0, 1'b0));
    drain();
    write_register(REG_TICK_RATE, {16'd0, RATE_60HZ});
    send_item(make_item(63'd4000, 1'b0, '0, 1'b0));
    send_item(make_item(63'd5000, 1'b0, '0, 1'b1));
  endtask

  // Field extremes, local tick saturation and both estimate saturations
  task automatic test_field_extremes();
    set_config(RATE_MAX, WINDOW_MAX, DELAY_MAX);
    send_item(make_item('0, 1'b1, TICK_MAX, 1'b0));
    send_item(make_item(NOW_MAX, 1'b0, '0, 1'b0));
    send_item(make_item(NOW_MAX, 1'b1, '0, 1'b1));
    send_item(make_item('0, 1'b0, '0, 1'b0));
    send_item(make_item(NOW_MAX, 1'b1, TICK_MAX, 1'b0));
    send_item(make_item(NOW_MAX, 1'b0, TICK_MAX, 1'b1));
  endtask

  // Expiry at the window edge, clock going backwards, front-only expiry, equal offsets
  task automatic test_window_expiry();
    set_config(48'd1, 40'd100, '0);
    send_item(make_item(63'd1000, 1'b1, 40'd50, 1'b1));
    send_item(make_item(63'd10, 1'b1, 40'd40, 1'b0));
    send_item(make_item(63'd200, 1'b1, 40'd30, 1'b0));
    send_item(make_item(63'd1101, 1'b1, 40'd20, 1'b0));
    send_item(make_item(63'd1201, 1'b1, 40'd10, 1'b0));
    send_item(make_item(63'd1202, 1'b1, 40'd5, 1'b0));
    send_item(make_item(63'd1203, 1'b1, 40'd30, 1'b0));
    send_item(make_item(63'd5000, 1'b0, '0, 1'b0));
    drain();
    write_register(REG_WINDOW_NS, '0);
    send_item(make_item(63'd6000, 1'b1, 40'd7, 1'b0));
    send_item(make_item(63'd6000, 1'b1, 40'd6, 1'b0));
    send_item(make_item(63'd6001, 1'b1, 40'd5, 1'b0));
    send_item(make_item(63'd6001, 1'b1, 40'd5, 1'b0));
  endtask

  // Phases of tracking bursts, descending runs that fill the deque, and noise
  task automatic test_random_phases();
    int                  sent;
    int                  len;
    int                  kind;
    int                  k;
    int                  run_lead;
    logic [RATE_W-1:0]   rate;
    logic [WINDOW_W-1:0] win;
    logic [DELAY_W-1:0]  dly;
    logic [63:0]         step_max;
    logic                clr;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          rate = RATE_60HZ;
          win  = WINDOW_RESET;
          dly  = '0;
        end
        1: begin
          rate = RATE_MAX;
          win  = '0;
          dly  = DELAY_MAX;
        end
        2: begin
          rate = '0;
          win  = WINDOW_MAX;
          dly  = $urandom;
        end
        3: begin
          rate = 48'd1;
          win  = 40'd1000;
          dly  = $urandom_range(100);
        end
        default: begin
          case ($urandom_range(4))
            0: rate = '0;
            1: rate = RATE_MAX;
            2: rate = RATE_W'({$urandom, $urandom});
            3: rate = RATE_W'($urandom_range(100000000, 1000000));
            default: rate = 48'd1;
          endcase
          case ($urandom_range(3))
            0: win = WINDOW_W'($urandom_range(1000));
            1: win = WINDOW_RESET;
            2: win = WINDOW_W'({$urandom, $urandom});
            default: win = WINDOW_MAX;
          endcase
          case ($urandom_range(2))
            0: dly = '0;
            1: dly = $urandom_range(1000);
            default: dly = $urandom;
          endcase
        end
      endcase
      set_config(rate, win, dly);
      no_idle   = (phase == 6);
      clock_now = rand_now() >> $urandom_range(62);
      step_max  = (64'(win) >> 2) + 3;
      if (step_max > 64'hFFFF_FFFF)
        step_max = 64'hFFFF_FFFF;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 40)
          len = $urandom_range(12, 3);
        else if (kind < 70)
          len = ($urandom_range(3) == 0) ? $urandom_range(HISTORY_DEPTH + 8, HISTORY_DEPTH + 1)
                                         : $urandom_range(10, 2);
        else
          len = $urandom_range(4, 1);
        k        = 0;
        run_lead = $urandom_range(100000, 64);
        for (int n = 0; n < len; n++) begin
          // advance the local clock; now and then hold it or step it back
          case ($urandom_range(19))
            0: clock_now = clock_now - NOW_W'($urandom_range(50));
            1: ;
            default: clock_now = clock_now + NOW_W'($urandom_range(step_max[31:0], 1));
          endcase
          clr = (n == 0) && ($urandom_range(9) == 0);
          if (kind < 40) begin
            send_item(make_item(clock_now, $urandom_range(3) != 0,
                                tick_near(clock_now, int'($urandom_range(6)) - 3), clr));
          end else if (kind < 70) begin
            k += $urandom_range(3, 1);
            send_item(make_item(clock_now, 1'b1, tick_near(clock_now, run_lead - k), clr));
          end else begin
            send_item(make_item(rand_now(), 1'($urandom_range(1)),
                                TICK_W'({$urandom, $urandom}), $urandom_range(15) == 0));
          end
        end
        sent += len;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_rate_zero();
    test_field_extremes();
    test_window_expiry();
    test_random_phases();
    drain();
    if (fail_count == 0 && expected_estimates.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
